// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the gradient angle RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/gad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_pkg
// Widths, CORDIC angle table and shared types for the gradient angle block.
// ----------------------------------------------------------------------------
package gad_pkg;

    localparam int COMPONENT_WIDTH = 12;
    localparam int FRACTION_BITS   = 7;

    localparam int ANGLE_W      = 16;
    localparam int ANG_GUARD    = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int NORM_MSB     = 57;
    // normalized vector below 2^58.5, CORDIC gain 1.65: fits 62 bits signed
    localparam int DATA_W       = 62;
    localparam int Z_W          = 32;
    localparam int TOTAL_W      = 34;
    localparam int MAG_W        = COMPONENT_WIDTH;
    localparam int MSB_W        = $clog2(MAG_W);
    localparam int SHIFT_W      = $clog2(NORM_MSB + 1);
    localparam int ROUND_SHIFT  = ANG_GUARD - FRACTION_BITS;
    localparam int RES_W        = TOTAL_W - ROUND_SHIFT;

    localparam logic [RES_W-1:0]   FULL_TURN  = RES_W'(360 * 2**FRACTION_BITS);
    localparam logic [RES_W-1:0]   DEG_90     = RES_W'(90 * 2**FRACTION_BITS);
    localparam logic [RES_W-1:0]   DEG_180    = RES_W'(180 * 2**FRACTION_BITS);
    localparam logic [RES_W-1:0]   DEG_270    = RES_W'(270 * 2**FRACTION_BITS);
    localparam logic [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(2**(ROUND_SHIFT - 1));

    // atan(2^-i) in degrees, scaled by 2^24
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466,
        938734, 469367, 234684, 117342, 58671,
        29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57,
        29, 14, 7, 4, 2
    };

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    // sideband that rides along the CORDIC stages
    typedef struct packed {
        logic             special;
        logic [RES_W-1:0] special_res;
        t_quad            quad;
    } t_side;

    function automatic logic [8:0] quad_base(input t_quad q);
        logic [8:0] deg;
        unique case (q)
            QUAD_0:   deg = 9'd0;
            QUAD_90:  deg = 9'd90;
            QUAD_180: deg = 9'd180;
            QUAD_270: deg = 9'd270;
            default:  deg = 9'd0;
        endcase
        return deg;
    endfunction

endpackage

// ===== hw/rtl/gad_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_intf
// Request and result channels of the gradient angle block.
// ----------------------------------------------------------------------------
interface gad_in_if import gad_pkg::*; ();
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] grad_x;
    logic signed [COMPONENT_WIDTH-1:0] grad_y;

    modport source (output valid, output grad_x, output grad_y, input ready);
    modport sink   (input valid, input grad_x, input grad_y, output ready);
endinterface

interface gad_out_if import gad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

// ===== hw/rtl/gad_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_prep
// Folds the vector into the first quadrant, then normalizes it (two stages).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gad_prep import gad_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic signed [COMPONENT_WIDTH-1:0] i_grad_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_grad_y,
    output logic                              o_valid,
    output logic signed [DATA_W-1:0]          o_x,
    output logic signed [DATA_W-1:0]          o_y,
    output t_side                             o_side
);

    logic               xn, yn;
    logic [MAG_W-1:0]   xm, ym;
    logic [MAG_W-1:0]   n_a, n_b;
    t_side              n_side;

    logic               r_v1;
    logic [MAG_W-1:0]   r_a, r_b;
    t_side              r_side1;

    logic [MAG_W-1:0]   mx;
    logic [MSB_W-1:0]   msb;
    logic [SHIFT_W-1:0] n_shift;

    logic                     r_v2;
    logic signed [DATA_W-1:0] r_x2, r_y2;
    t_side                    r_side2;

    // stage 1: magnitudes, quadrant and axis cases
    always_comb begin
        xn = i_grad_x[COMPONENT_WIDTH-1];
        yn = i_grad_y[COMPONENT_WIDTH-1];
        // the most negative value comes out as 2^(w-1), exact in w bits
        xm = xn ? MAG_W'(-i_grad_x) : MAG_W'(i_grad_x);
        ym = yn ? MAG_W'(-i_grad_y) : MAG_W'(i_grad_y);

        n_side.special     = (xm == '0) || (ym == '0);
        n_side.special_res = '0;
        if (xm == '0) begin
            n_side.special_res = yn ? DEG_270 : DEG_90;
        end else if (ym == '0) begin
            n_side.special_res = xn ? DEG_180 : '0;
        end

        if (!xn && !yn) begin
            n_side.quad = QUAD_0;
            n_a = xm;
            n_b = ym;
        end else if (xn && !yn) begin
            n_side.quad = QUAD_90;
            n_a = ym;
            n_b = xm;
        end else if (xn && yn) begin
            n_side.quad = QUAD_180;
            n_a = xm;
            n_b = ym;
        end else begin
            n_side.quad = QUAD_270;
            n_a = ym;
            n_b = xm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_side1 <= n_side;
        end
    end

    // stage 2: bring the larger component's top bit up to NORM_MSB
    always_comb begin
        mx  = (r_a > r_b) ? r_a : r_b;
        msb = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (mx[k]) begin
                msb = MSB_W'(k);
            end
        end
        n_shift = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x2    <= $signed(DATA_W'(r_a) << n_shift);
            r_y2    <= $signed(DATA_W'(r_b) << n_shift);
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x2;
    assign o_y     = r_y2;
    assign o_side  = r_side2;

    `ASSERT_CLK(a_norm_range, i_clk, i_rst_n,
        !r_v2 || r_side2.special || ((r_x2[NORM_MSB] || r_y2[NORM_MSB])
        && r_x2[DATA_W-1:NORM_MSB+1] == '0 && r_y2[DATA_W-1:NORM_MSB+1] == '0),
        "normalized vector out of range")

endmodule

// ===== hw/rtl/gad_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_cordic
// Vectoring CORDIC, one registered stage per iteration.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gad_cordic import gad_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    input  t_side                    i_side,
    output logic                     o_valid,
    output logic signed [Z_W-1:0]    o_z,
    output t_side                    o_side
);

    localparam int LAST = CORDIC_STEPS - 1;

    logic                     r_v    [CORDIC_STEPS];
    logic signed [DATA_W-1:0] r_x    [CORDIC_STEPS];
    logic signed [DATA_W-1:0] r_y    [CORDIC_STEPS];
    logic signed [Z_W-1:0]    r_z    [CORDIC_STEPS];
    t_side                    r_side [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic                     v_in;
        logic signed [DATA_W-1:0] x_in, y_in, xs, ys;
        logic signed [DATA_W-1:0] n_x, n_y;
        logic signed [Z_W-1:0]    z_in, n_z;
        t_side                    side_in;

        if (i == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_x;
            assign y_in    = i_y;
            assign z_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[i-1];
            assign x_in    = r_x[i-1];
            assign y_in    = r_y[i-1];
            assign z_in    = r_z[i-1];
            assign side_in = r_side[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        // rotate toward the x axis; y sign picks the direction
        always_comb begin
            if (!y_in[DATA_W-1]) begin
                n_x = x_in + ys;
                n_y = y_in - xs;
                n_z = z_in + ATAN_TAB[i];
            end else begin
                n_x = x_in - ys;
                n_y = y_in + xs;
                n_z = z_in - ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_adv) begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[i]    <= n_x;
                r_y[i]    <= n_y;
                r_z[i]    <= n_z;
                r_side[i] <= side_in;
            end
        end
    end

    assign o_valid = r_v[LAST];
    assign o_z     = r_z[LAST];
    assign o_side  = r_side[LAST];

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !i_adv,
        $stable(r_v[LAST]) && $stable(r_z[LAST]), "pipeline moved while stalled")
    `ASSERT_CLK(a_quad_angle, i_clk, i_rst_n,
        !r_v[LAST] || r_side[LAST].special
        || (r_z[LAST] > 0 && r_z[LAST] < $signed(Z_W'(90 * 2**ANG_GUARD))),
        "first quadrant angle out of range")

endmodule

// ===== hw/rtl/gad_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gad_round
// Adds the quadrant base, rounds to the output grid and wraps a full turn.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gad_round import gad_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic signed [Z_W-1:0] i_z,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [ANGLE_W-1:0]    o_angle
);

    logic signed [TOTAL_W-1:0] n_total;
    logic                      r_v1;
    logic signed [TOTAL_W-1:0] r_total;
    t_side                     r_side1;

    logic [TOTAL_W-1:0] pos;
    logic [TOTAL_W-1:0] sum;
    logic [RES_W-1:0]   rnd;
    logic [RES_W-1:0]   n_res;
    logic               r_v2;
    logic [RES_W-1:0]   r_res;

    assign n_total = $signed(TOTAL_W'(quad_base(i_side.quad)) << ANG_GUARD)
                   + TOTAL_W'(i_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_total <= n_total;
            r_side1 <= i_side;
        end
    end

    // clamp below zero, round half up, fold 360 back to 0; axis cases take their preset result
    always_comb begin
        pos = r_total[TOTAL_W-1] ? '0 : TOTAL_W'(r_total);
        sum = pos + ROUND_HALF;
        rnd = RES_W'(sum >> ROUND_SHIFT);
        if (r_side1.special) begin
            n_res = r_side1.special_res;
        end else if (rnd >= FULL_TURN) begin
            n_res = rnd - FULL_TURN;
        end else begin
            n_res = rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v2;
    assign o_angle = ANGLE_W'(r_res);

    `ASSERT_CLK(a_res_below_turn, i_clk, i_rst_n, !r_v2 || r_res < FULL_TURN,
        "angle not below a full turn")

endmodule

// ===== hw/rtl/gradient_angle_degrees.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_angle_degrees
// Four-quadrant arctangent of a gradient vector, in 1/128 degree units.
// ----------------------------------------------------------------------------
//  channel  dir  fields                     handshake
//  i_req    in   grad_x, grad_y (12b sgn)   valid / ready
//  o_rsp    out  angle (16b unsigned)       valid / ready
//
//  The pipeline has 2 prep stages, 30 CORDIC stages and 2 round stages.
//  One request is taken per cycle unless the output stalls; the 30 CORDIC stages set the depth.
//  Reset (synchronous, active low) clears only the stage valid bits.
//  When the output holds a result that is not taken, the whole pipeline
//  freezes and i_req.ready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gradient_angle_degrees import gad_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gad_in_if.sink     i_req,
    gad_out_if.source  o_rsp
);

    logic                     w_adv;
    logic                     w_prep_v;
    logic signed [DATA_W-1:0] w_prep_x, w_prep_y;
    t_side                    w_prep_side;
    logic                     w_cor_v;
    logic signed [Z_W-1:0]    w_cor_z;
    t_side                    w_cor_side;
    logic                     w_out_v;
    logic [ANGLE_W-1:0]       w_out_angle;

    // advance unless a finished result is waiting
    assign w_adv       = !w_out_v || o_rsp.ready;
    assign i_req.ready = w_adv;

    gad_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_req.valid),
        .i_grad_x (i_req.grad_x),
        .i_grad_y (i_req.grad_y),
        .o_valid  (w_prep_v),
        .o_x      (w_prep_x),
        .o_y      (w_prep_y),
        .o_side   (w_prep_side)
    );

    gad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_prep_v),
        .i_x     (w_prep_x),
        .i_y     (w_prep_y),
        .i_side  (w_prep_side),
        .o_valid (w_cor_v),
        .o_z     (w_cor_z),
        .o_side  (w_cor_side)
    );

    gad_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_cor_v),
        .i_z     (w_cor_z),
        .i_side  (w_cor_side),
        .o_valid (w_out_v),
        .o_angle (w_out_angle)
    );

    assign o_rsp.valid = w_out_v;
    assign o_rsp.angle = w_out_angle;

    `ASSERT_CLK(a_ready_follows_output, i_clk, i_rst_n,
        i_req.ready == (!w_out_v || o_rsp.ready), "request ready out of step with output")

endmodule
